FILE: src/bsc_pkg.sv
package bsc_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_COEF_SIGNED_A   = 3'd0,
		CFG_COEF_UNSIGNED_A = 3'd1,
		CFG_COEF_B_PAIR     = 3'd2,
		CFG_COEF_M_PAIR     = 3'd3,
		CFG_OVERSAMPLING    = 3'd4
	} cfg_index_t;

	// Calibration set, unpacked from the configuration registers
	typedef struct packed {
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic        [15:0] ac4;
		logic        [15:0] ac5;
		logic        [15:0] ac6;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic signed [15:0] mc;
		logic signed [15:0] md;
		logic        [1:0]  oss;
	} coef_t;

	// Carried alongside the temperature divider
	typedef struct packed {
		logic [17:0] x1;
		logic [18:0] up;
		logic        neg;
		logic        fault;
	} t_side_t;

	// Carried alongside the pressure divider
	typedef struct packed {
		logic [27:0] b5;
		logic        b7_hi;
		logic        fault;
	} p_side_t;

	localparam logic [27:0] B6_OFFSET  = 28'd4000;
	localparam logic [31:0] X3_BIAS    = 32'd32768;
	localparam logic [31:0] P_SCALE    = 32'd50000;
	localparam logic [11:0] P_SQ_COEF  = 12'd3038;
	localparam logic [12:0] P_LIN_COEF = 13'd7357;   // applied with negative sign
	localparam logic [47:0] P_BIAS     = 48'd3791;
	localparam logic [27:0] TW_ROUND   = 28'd8;
	localparam logic [23:0] RECIP_5    = 24'd13421773; // ceil(2^26 / 5)
	localparam logic [18:0] RECIP_100  = 19'd335545;   // ceil(2^25 / 100)

endpackage

FILE: src/bsc_div_pipe.sv
module bsc_div_pipe import bsc_pkg::*; #(
	parameter int NW = 32,
	parameter int DW = 17,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [NW-1:0] quot,
	output logic [DW-1:0] rem,
	output logic [DW-1:0] den_o,
	output logic [SW-1:0] side_o
);

	// One quotient bit per stage, restoring
	logic [NW-1:0] valid_q;
	logic [NW-1:0] en;
	logic [NW-1:0] valid_nxt;

	logic [DW-1:0] rem_s  [NW];
	logic [NW-1:0] num_s  [NW];
	logic [DW-1:0] den_s  [NW];
	logic [SW-1:0] side_s [NW];

	assign en[NW-1]  = !valid_q[NW-1] || out_ready;
	assign valid_nxt = {valid_q[NW-2:0], in_valid};

	genvar k;
	generate
		for (k = 0; k < NW - 1; k++) begin : g_en
			assign en[k] = !valid_q[k] || en[k+1];
		end

		for (k = 0; k < NW; k++) begin : g_stg
			logic [DW-1:0] rem_in;
			logic [NW-1:0] num_in;
			logic [DW-1:0] den_in;
			logic [SW-1:0] side_in;
			logic [DW:0]   trial;
			logic [DW:0]   diff;
			logic          ge;

			if (k == 0) begin : g_first
				assign rem_in  = '0;
				assign num_in  = num;
				assign den_in  = den;
				assign side_in = side;
			end else begin : g_next
				assign rem_in  = rem_s[k-1];
				assign num_in  = num_s[k-1];
				assign den_in  = den_s[k-1];
				assign side_in = side_s[k-1];
			end

			assign trial = {rem_in, num_in[NW-1]};
			assign diff  = trial - {1'b0, den_in};
			assign ge    = trial >= {1'b0, den_in};

			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
					num_s[k]  <= {num_in[NW-2:0], ge};
					den_s[k]  <= den_in;
					side_s[k] <= side_in;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < NW; i++) begin
				if (en[i]) valid_q[i] <= valid_nxt[i];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_q[NW-1];
	assign quot      = num_s[NW-1];
	assign rem       = rem_s[NW-1];
	assign den_o     = den_s[NW-1];
	assign side_o    = side_s[NW-1];

endmodule

FILE: src/bsc_front.sv
module bsc_front import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  coef_t       coef,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] raw_temperature,
	input  logic [18:0] raw_pressure,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [26:0] num,
	output logic [17:0] den,
	output t_side_t     side
);

	localparam int NS = 4;

	logic [NS-1:0] valid_q;
	logic [NS-1:0] en;
	logic [NS-1:0] valid_nxt;

	logic signed [16:0] dt_s1;
	logic        [18:0] up_s1;
	logic signed [33:0] prod_s2;
	logic        [18:0] up_s2;
	logic        [17:0] x1_s3;
	logic        [18:0] dv_s3;
	logic        [18:0] up_s3;
	logic        [17:0] x1_s4;
	logic        [18:0] up_s4;
	logic        [26:0] nmag_s4;
	logic        [17:0] dmag_s4;
	logic               neg_s4;
	logic               fault_s4;

	logic signed [33:0] prod;
	logic        [18:0] dv_neg;
	logic        [15:0] mc_neg;
	logic        [15:0] mc_mag;

	assign en[NS-1]  = !valid_q[NS-1] || out_ready;
	assign valid_nxt = {valid_q[NS-2:0], in_valid};

	genvar k;
	generate
		for (k = 0; k < NS - 1; k++) begin : g_en
			assign en[k] = !valid_q[k] || en[k+1];
		end
	endgenerate

	assign prod   = dt_s1 * $signed({1'b0, coef.ac5});
	assign dv_neg = 19'd0 - dv_s3;
	assign mc_neg = 16'd0 - coef.mc;
	assign mc_mag = coef.mc[15] ? mc_neg : coef.mc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (en[i]) valid_q[i] <= valid_nxt[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.ac6});
			up_s1 <= raw_pressure;
		end
		if (en[1]) begin
			prod_s2 <= prod;
			up_s2   <= up_s1;
		end
		if (en[2]) begin
			x1_s3 <= prod_s2[32:15];
			dv_s3 <= {prod_s2[32], prod_s2[32:15]} + {{3{coef.md[15]}}, coef.md};
			up_s3 <= up_s2;
		end
		if (en[3]) begin
			x1_s4    <= x1_s3;
			up_s4    <= up_s3;
			nmag_s4  <= {mc_mag, 11'd0};
			dmag_s4  <= dv_s3[18] ? dv_neg[17:0] : dv_s3[17:0];
			neg_s4   <= coef.mc[15] ^ dv_s3[18];
			fault_s4 <= (dv_s3 == 19'd0);
		end
	end

	assign in_ready   = en[0];
	assign out_valid  = valid_q[NS-1];
	assign num        = nmag_s4;
	assign den        = dmag_s4;
	assign side.x1    = x1_s4;
	assign side.up    = up_s4;
	assign side.neg   = neg_s4;
	assign side.fault = fault_s4;

endmodule

FILE: src/bsc_mid.sv
module bsc_mid import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  coef_t       coef,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [26:0] quot,
	input  t_side_t     side,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] num,
	output logic [16:0] den,
	output p_side_t     side_o
);

	localparam int NS = 10;

	logic [NS-1:0] valid_q;
	logic [NS-1:0] en;
	logic [NS-1:0] valid_nxt;

	// B5 and the fault flag ride along every stage
	logic [27:0] b5_s1, b5_s2, b5_s3, b5_s4, b5_s5, b5_s6, b5_s7, b5_s8, b5_s9, b5_s10;
	logic        flt_s1, flt_s2, flt_s3, flt_s4, flt_s5, flt_s6, flt_s7, flt_s8, flt_s9;
	logic        flt_s10;
	logic [18:0] up_s1, up_s2, up_s3, up_s4, up_s5, up_s6, up_s7, up_s8;

	logic signed [27:0] b6_s2;
	logic        [53:0] sq_s3;
	logic signed [43:0] pa2_s3;
	logic signed [43:0] pa3_s3;
	logic signed [58:0] pb2_s4;
	logic signed [58:0] pb1_s4;
	logic        [32:0] xa2_s4;
	logic        [30:0] xc1_s4;
	logic signed [48:0] x3a_s5;
	logic        [43:0] x3c_s5;
	logic        [49:0] w_s6;
	logic        [31:0] c32_s6;
	logic signed [52:0] v_s7;
	logic        [16:0] b4_s7, b4_s8, b4_s9, b4_s10;
	logic        [31:0] b3_s8;
	logic        [31:0] diff_s9;
	logic        [31:0] b7_s10;

	logic        [27:0] qx;
	logic        [27:0] x2;
	logic signed [55:0] sq_full;
	logic signed [43:0] pa2;
	logic signed [43:0] pa3;
	logic        [41:0] t12;
	logic signed [58:0] pb2;
	logic signed [58:0] pb1;
	logic signed [52:0] w_ext;
	logic        [47:0] b4p;
	logic        [15:0] pscale;
	logic        [31:0] pscale_w;
	logic        [47:0] b7p;

	assign en[NS-1]  = !valid_q[NS-1] || out_ready;
	assign valid_nxt = {valid_q[NS-2:0], in_valid};

	genvar k;
	generate
		for (k = 0; k < NS - 1; k++) begin : g_en
			assign en[k] = !valid_q[k] || en[k+1];
		end
	endgenerate

	assign qx       = {1'b0, quot};
	assign x2       = side.neg ? (28'd0 - qx) : qx;
	assign sq_full  = b6_s2 * b6_s2;
	assign pa2      = $signed(coef.ac2) * b6_s2;
	assign pa3      = $signed(coef.ac3) * b6_s2;
	assign t12      = sq_s3[53:12];
	assign pb2      = $signed(coef.b2) * $signed({1'b0, t12});
	assign pb1      = $signed(coef.b1) * $signed({1'b0, t12});
	assign w_ext    = $signed({{3{w_s6[49]}}, w_s6});
	assign b4p      = coef.ac4 * c32_s6;
	assign pscale_w = P_SCALE >> coef.oss;
	assign pscale   = pscale_w[15:0];
	assign b7p      = diff_s9 * pscale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (en[i]) valid_q[i] <= valid_nxt[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			b5_s1  <= x2 + {{10{side.x1[17]}}, side.x1};
			flt_s1 <= side.fault;
			up_s1  <= side.up;
		end
		if (en[1]) begin
			b6_s2  <= b5_s1 - B6_OFFSET;
			b5_s2  <= b5_s1;
			flt_s2 <= flt_s1;
			up_s2  <= up_s1;
		end
		if (en[2]) begin
			sq_s3  <= sq_full[53:0];
			pa2_s3 <= pa2;
			pa3_s3 <= pa3;
			b5_s3  <= b5_s2;
			flt_s3 <= flt_s2;
			up_s3  <= up_s2;
		end
		if (en[3]) begin
			pb2_s4 <= pb2;
			pb1_s4 <= pb1;
			xa2_s4 <= pa2_s3[43:11];
			xc1_s4 <= pa3_s3[43:13];
			b5_s4  <= b5_s3;
			flt_s4 <= flt_s3;
			up_s4  <= up_s3;
		end
		if (en[4]) begin
			x3a_s5 <= {pb2_s4[58], pb2_s4[58:11]} + {{16{xa2_s4[32]}}, xa2_s4};
			x3c_s5 <= {pb1_s4[58], pb1_s4[58:16]} + {{13{xc1_s4[30]}}, xc1_s4} + 44'd2;
			b5_s5  <= b5_s4;
			flt_s5 <= flt_s4;
			up_s5  <= up_s4;
		end
		if (en[5]) begin
			w_s6   <= {{32{coef.ac1[15]}}, coef.ac1, 2'b00} + {x3a_s5[48], x3a_s5};
			c32_s6 <= x3c_s5[33:2] + X3_BIAS;
			b5_s6  <= b5_s5;
			flt_s6 <= flt_s5;
			up_s6  <= up_s5;
		end
		if (en[6]) begin
			v_s7   <= (w_ext <<< coef.oss) + 53'sd2;
			b4_s7  <= b4p[31:15];
			b5_s7  <= b5_s6;
			flt_s7 <= flt_s6;
			up_s7  <= up_s6;
		end
		if (en[7]) begin
			// divide by four, truncating toward zero
			b3_s8  <= v_s7[33:2] + {31'd0, v_s7[52] & (v_s7[1:0] != 2'b00)};
			b4_s8  <= b4_s7;
			flt_s8 <= flt_s7 | (b4_s7 == 17'd0);
			b5_s8  <= b5_s7;
			up_s8  <= up_s7;
		end
		if (en[8]) begin
			diff_s9 <= {13'd0, up_s8} - b3_s8;
			b4_s9   <= b4_s8;
			flt_s9  <= flt_s8;
			b5_s9   <= b5_s8;
		end
		if (en[9]) begin
			b7_s10  <= b7p[31:0];
			b4_s10  <= b4_s9;
			flt_s10 <= flt_s9;
			b5_s10  <= b5_s9;
		end
	end

	assign in_ready     = en[0];
	assign out_valid    = valid_q[NS-1];
	assign num          = b7_s10;
	assign den          = b4_s10;
	assign side_o.b5    = b5_s10;
	assign side_o.b7_hi = b7_s10[31];
	assign side_o.fault = flt_s10;

endmodule

FILE: src/bsc_back.sv
module bsc_back import bsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [31:0] quot,
	input  logic        [16:0] rem,
	input  logic        [16:0] den,
	input  p_side_t            side,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] temp_tenths,
	output logic signed [12:0] temp_whole,
	output logic        [17:0] pressure_pa,
	output logic        [11:0] pressure_hpa,
	output logic               divide_fault
);

	localparam int NS = 7;

	logic [NS-1:0] valid_q;
	logic [NS-1:0] en;
	logic [NS-1:0] valid_nxt;

	logic        [32:0] q_s1, q_s2, q_s3, q_s4;
	logic signed [27:0] tv_s1;
	logic               flt_s1, flt_s2, flt_s3, flt_s4, flt_s5, flt_s6, flt_s7;
	logic        [49:0] pu2_s2;
	logic        [45:0] pm_s2;
	logic        [15:0] tt_s2, tt_s3, tt_s4, tt_s5, tt_s6, tt_s7;
	logic        [21:0] tm5_s2;
	logic               tneg_s2, tneg_s3;
	logic        [61:0] x1p_s3;
	logic        [30:0] x2_s3;
	logic        [45:0] twp_s3;
	logic        [47:0] s_s4;
	logic        [12:0] tw_s4, tw_s5, tw_s6, tw_s7;
	logic        [17:0] pa_s5, pa_s6, pa_s7;
	logic        [36:0] hp_s6;
	logic        [11:0] hpa_s7;

	logic               lowbit;
	logic        [24:0] pu;
	logic        [49:0] pu2;
	logic        [45:0] pm;
	logic signed [23:0] ts;
	logic        [27:0] tv_neg;
	logic        [27:0] tmag;
	logic        [46:0] negpm;
	logic        [61:0] x1p;
	logic        [45:0] twp;
	logic        [19:0] tq;
	logic signed [44:0] pf;
	logic        [36:0] hp;

	assign en[NS-1]  = !valid_q[NS-1] || out_ready;
	assign valid_nxt = {valid_q[NS-2:0], in_valid};

	genvar k;
	generate
		for (k = 0; k < NS - 1; k++) begin : g_en
			assign en[k] = !valid_q[k] || en[k+1];
		end
	endgenerate

	// small quotients keep the extra bit from twice the remainder
	assign lowbit = !side.b7_hi && ({rem, 1'b0} >= {1'b0, den});
	assign pu     = q_s1[32:8];
	assign pu2    = pu * pu;
	assign pm     = q_s1 * P_LIN_COEF;
	assign ts     = tv_s1[27:4];
	assign tv_neg = 28'd0 - tv_s1;
	assign tmag   = tv_s1[27] ? tv_neg : tv_s1;
	assign negpm  = 47'd0 - {1'b0, pm_s2};
	assign x1p    = pu2_s2 * P_SQ_COEF;
	assign twp    = tm5_s2 * RECIP_5;
	assign tq     = twp_s3[45:26];
	assign pf     = $signed({12'd0, q_s4}) + $signed({s_s4[47], s_s4[47:4]});
	assign hp     = pa_s5 * RECIP_100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (en[i]) valid_q[i] <= valid_nxt[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			q_s1   <= {quot, lowbit};
			tv_s1  <= side.b5 + TW_ROUND;
			flt_s1 <= side.fault;
		end
		if (en[1]) begin
			pu2_s2  <= pu2;
			pm_s2   <= pm;
			q_s2    <= q_s1;
			flt_s2  <= flt_s1;
			tm5_s2  <= tmag[26:5];
			tneg_s2 <= tv_s1[27];
			if (ts > 24'sd32767) tt_s2 <= 16'h7FFF;
			else if (ts < -24'sd32768) tt_s2 <= 16'h8000;
			else tt_s2 <= ts[15:0];
		end
		if (en[2]) begin
			x1p_s3  <= x1p;
			x2_s3   <= negpm[46:16];
			twp_s3  <= twp;
			q_s3    <= q_s2;
			tt_s3   <= tt_s2;
			tneg_s3 <= tneg_s2;
			flt_s3  <= flt_s2;
		end
		if (en[3]) begin
			s_s4   <= {2'b00, x1p_s3[61:16]} + {{17{x2_s3[30]}}, x2_s3} + P_BIAS;
			q_s4   <= q_s3;
			tt_s4  <= tt_s3;
			flt_s4 <= flt_s3;
			if (tneg_s3) tw_s4 <= (tq > 20'd4096) ? 13'h1000 : 13'd0 - tq[12:0];
			else tw_s4 <= (tq > 20'd4095) ? 13'h0FFF : tq[12:0];
		end
		if (en[4]) begin
			if (pf[44]) pa_s5 <= 18'd0;
			else if (pf > 45'sd262143) pa_s5 <= 18'h3FFFF;
			else pa_s5 <= pf[17:0];
			tt_s5  <= tt_s4;
			tw_s5  <= tw_s4;
			flt_s5 <= flt_s4;
		end
		if (en[5]) begin
			hp_s6  <= hp;
			pa_s6  <= pa_s5;
			tt_s6  <= tt_s5;
			tw_s6  <= tw_s5;
			flt_s6 <= flt_s5;
		end
		if (en[6]) begin
			// a zero divisor anywhere clears every result field
			tt_s7  <= flt_s6 ? 16'd0 : tt_s6;
			tw_s7  <= flt_s6 ? 13'd0 : tw_s6;
			pa_s7  <= flt_s6 ? 18'd0 : pa_s6;
			hpa_s7 <= flt_s6 ? 12'd0 : hp_s6[36:25];
			flt_s7 <= flt_s6;
		end
	end

	assign in_ready     = en[0];
	assign out_valid    = valid_q[NS-1];
	assign temp_tenths  = tt_s7;
	assign temp_whole   = tw_s7;
	assign pressure_pa  = pa_s7;
	assign pressure_hpa = hpa_s7;
	assign divide_fault = flt_s7;

endmodule

FILE: src/baro_sensor_compensation_core.sv
// Barometric sensor compensation core.
// Raw channel (raw_valid / raw_stall): one beat carries a raw temperature word
// and a raw pressure word. Result channel (res_valid / res_stall): one beat per
// raw beat, in order, with temperature in tenths and whole degrees, pressure in
// pascal and hectopascal, and a divide fault flag that zeroes all the fields.
// Configuration channel (cfg_valid / cfg_ready): cfg_ready is always high;
// cfg_index picks the register (coefficient sets, then oversampling).
// Write it only while no beat is in flight.
// The path from raw beat to result beat runs through 4 front stages, a
// 27-stage temperature divider, 10 pressure-term stages, a 32-stage pressure
// divider and 7 back-end stages ending in the output register. One beat per
// cycle is sustained unless res_stall holds it; each divider stage resolves
// one quotient bit. Every stage moves on when it is empty or the stage after
// it moves, so a stalled result holds in the output register while bubbles
// upstream close up; raw_stall rises only once the whole pipeline is full.
// Reset clears all valid bits and the coefficients, and sets oversampling
// to one.
module baro_sensor_compensation_core import bsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               raw_valid,
	output logic               raw_stall,
	input  logic        [15:0] raw_temperature,
	input  logic        [18:0] raw_pressure,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [15:0] temp_tenths,
	output logic signed [12:0] temp_whole,
	output logic        [17:0] pressure_pa,
	output logic        [11:0] pressure_hpa,
	output logic               divide_fault,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [2:0]  cfg_index,
	input  logic        [47:0] cfg_data
);

	logic [47:0] coef_signed_a_q;
	logic [47:0] coef_unsigned_a_q;
	logic [31:0] coef_b_pair_q;
	logic [31:0] coef_m_pair_q;
	logic [1:0]  oversampling_q;
	coef_t       coef;

	logic        front_ready;
	logic        f_valid;
	logic        f_ready;
	logic [26:0] f_num;
	logic [17:0] f_den;
	t_side_t     f_side;

	logic        d1_valid;
	logic        d1_ready;
	logic [26:0] d1_quot;
	t_side_t     d1_side;

	logic        m_valid;
	logic        m_ready;
	logic [31:0] m_num;
	logic [16:0] m_den;
	p_side_t     m_side;

	logic        d2_valid;
	logic        d2_ready;
	logic [31:0] d2_quot;
	logic [16:0] d2_rem;
	logic [16:0] d2_den;
	p_side_t     d2_side;

	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_signed_a_q   <= '0;
			coef_unsigned_a_q <= '0;
			coef_b_pair_q     <= '0;
			coef_m_pair_q     <= '0;
			oversampling_q    <= 2'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COEF_SIGNED_A:   coef_signed_a_q   <= cfg_data;
				CFG_COEF_UNSIGNED_A: coef_unsigned_a_q <= cfg_data;
				CFG_COEF_B_PAIR:     coef_b_pair_q     <= cfg_data[31:0];
				CFG_COEF_M_PAIR:     coef_m_pair_q     <= cfg_data[31:0];
				CFG_OVERSAMPLING:    oversampling_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// The user keeps coefficients stable while beats are in flight (not enforced); every stage reads them
	assign coef.ac1 = coef_signed_a_q[47:32];
	assign coef.ac2 = coef_signed_a_q[31:16];
	assign coef.ac3 = coef_signed_a_q[15:0];
	assign coef.ac4 = coef_unsigned_a_q[47:32];
	assign coef.ac5 = coef_unsigned_a_q[31:16];
	assign coef.ac6 = coef_unsigned_a_q[15:0];
	assign coef.b1  = coef_b_pair_q[31:16];
	assign coef.b2  = coef_b_pair_q[15:0];
	assign coef.mc  = coef_m_pair_q[31:16];
	assign coef.md  = coef_m_pair_q[15:0];
	assign coef.oss = oversampling_q;

	assign raw_stall = !front_ready;

	// X1 and the operand magnitudes and sign of the temperature division
	bsc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.coef            (coef),
		.in_valid        (raw_valid),
		.in_ready        (front_ready),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.out_valid       (f_valid),
		.out_ready       (f_ready),
		.num             (f_num),
		.den             (f_den),
		.side            (f_side)
	);

	// MC * 2048 / (X1 + MD), magnitudes only
	bsc_div_pipe #(
		.NW (27),
		.DW (18),
		.SW ($bits(t_side_t))
	) u_div_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.num       (f_num),
		.den       (f_den),
		.side      (f_side),
		.out_valid (d1_valid),
		.out_ready (d1_ready),
		.quot      (d1_quot),
		.rem       (),
		.den_o     (),
		.side_o    (d1_side)
	);

	// B5, B6, B3, B4 and B7
	bsc_mid u_mid (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.in_valid  (d1_valid),
		.in_ready  (d1_ready),
		.quot      (d1_quot),
		.side      (d1_side),
		.out_valid (m_valid),
		.out_ready (m_ready),
		.num       (m_num),
		.den       (m_den),
		.side_o    (m_side)
	);

	// B7 / B4; the remainder finishes the doubled quotient
	bsc_div_pipe #(
		.NW (32),
		.DW (17),
		.SW ($bits(p_side_t))
	) u_div_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m_valid),
		.in_ready  (m_ready),
		.num       (m_num),
		.den       (m_den),
		.side      (m_side),
		.out_valid (d2_valid),
		.out_ready (d2_ready),
		.quot      (d2_quot),
		.rem       (d2_rem),
		.den_o     (d2_den),
		.side_o    (d2_side)
	);

	// Pressure correction, temperature scaling, saturation and output register
	bsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (d2_valid),
		.in_ready     (d2_ready),
		.quot         (d2_quot),
		.rem          (d2_rem),
		.den          (d2_den),
		.side         (d2_side),
		.out_valid    (res_valid),
		.out_ready    (!res_stall),
		.temp_tenths  (temp_tenths),
		.temp_whole   (temp_whole),
		.pressure_pa  (pressure_pa),
		.pressure_hpa (pressure_hpa),
		.divide_fault (divide_fault)
	);

endmodule

FILE: bench/baro_sensor_compensation_core_tb.sv
module baro_sensor_compensation_core_tb import bsc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// An index past the end of the register list; the block must ignore it.
	localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;
	// No beat accepted for this many cycles means the block hung.
	localparam int HANG_LIMIT = 5000;
	// Long enough to cover the pipeline with margin.
	localparam int DRAIN_CYCLES = 120;

	// Coefficient families used across the phases
	typedef enum int {
		CAL_DATASHEET,
		CAL_RANDOM,
		CAL_ZERO,
		CAL_ONES,
		CAL_EXTREME,
		CAL_NEAR_DATASHEET
	} cal_kind_t;

	typedef struct packed {
		logic signed [15:0] tenths;
		logic signed [12:0] whole;
		logic        [17:0] pa;
		logic        [11:0] hpa;
		logic               fault;
	} reading_t;

	class reading_scoreboard;
		logic [47:0] sgn_a, uns_a;
		logic [31:0] b_pair, m_pair;
		logic [1:0]  oss;
		reading_t    pending_q[$];
		int          mismatches;
		int          checked;
		int          faults_seen;

		function void reset_regs();
			sgn_a = '0;
			uns_a = '0;
			b_pair = '0;
			m_pair = '0;
			oss = 2'd1;
		endfunction

		function void write_reg(logic [2:0] idx, logic [47:0] data);
			case (idx)
				CFG_COEF_SIGNED_A:   sgn_a = data;
				CFG_COEF_UNSIGNED_A: uns_a = data;
				CFG_COEF_B_PAIR:     b_pair = data[31:0];
				CFG_COEF_M_PAIR:     m_pair = data[31:0];
				CFG_OVERSAMPLING:    oss = data[1:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		// Datasheet integer compensation; >>> on longint floors like the datasheet shifts.
		function reading_t compensate(logic [15:0] ut_raw, logic [18:0] up_raw);
			reading_t r;
			longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
			longint x1, x2, x3, den, b5, b6, b3, p, tt, tw, pa;
			bit [31:0] wrap32, b4, b7;
			bit [63:0] prod, q, pu, sq;
			r = '0;
			r.fault = 1'b1;
			ac1 = $signed(sgn_a[47:32]);
			ac2 = $signed(sgn_a[31:16]);
			ac3 = $signed(sgn_a[15:0]);
			ac4 = uns_a[47:32];
			ac5 = uns_a[31:16];
			ac6 = uns_a[15:0];
			b1 = $signed(b_pair[31:16]);
			b2 = $signed(b_pair[15:0]);
			mc = $signed(m_pair[31:16]);
			md = $signed(m_pair[15:0]);
			ut = ut_raw;

			x1 = ((ut - ac6) * ac5) >>> 15;
			den = x1 + md;
			if (den == 0)
				return r;
			x2 = (mc * 2048) / den;
			b5 = x1 + x2;

			b6 = b5 - 4000;
			x1 = (b2 * ((b6 * b6) >>> 12)) >>> 11;
			x2 = (ac2 * b6) >>> 11;
			x3 = x1 + x2;
			b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
			x1 = (ac3 * b6) >>> 13;
			x2 = (b1 * ((b6 * b6) >>> 12)) >>> 16;
			x3 = (x1 + x2 + 2) >>> 2;
			wrap32 = 32'(x3 + 32768);
			prod = {32'd0, wrap32} * 64'(ac4);
			b4 = prod[31:0] >> 15;
			if (b4 == 0)
				return r;
			wrap32 = {13'd0, up_raw} - 32'(b3);
			prod = {32'd0, wrap32} * (64'd50000 >> oss);
			b7 = prod[31:0];
			if (b7 < 32'h8000_0000)
				q = ({32'd0, b7} * 64'd2) / {32'd0, b4};
			else
				q = ({32'd0, b7} / {32'd0, b4}) * 64'd2;
			p = longint'(q);
			pu = q >> 8;
			sq = (pu * pu * 64'd3038) >> 16;
			x1 = longint'(sq);
			x2 = (-7357 * p) >>> 16;
			p = p + ((x1 + x2 + 3791) >>> 4);

			tt = clamp((b5 + 8) >>> 4, -32768, 32767);
			tw = clamp((b5 + 8) / 160, -4096, 4095);
			pa = clamp(p, 0, 262143);
			r.tenths = 16'(tt);
			r.whole = 13'(tw);
			r.pa = 18'(pa);
			r.hpa = 12'(pa / 100);
			r.fault = 1'b0;
			return r;
		endfunction

		function void note_raw(logic [15:0] ut_raw, logic [18:0] up_raw);
			pending_q.push_back(compensate(ut_raw, up_raw));
		endfunction

		function bit check_result(reading_t got);
			reading_t want;
			bit bad;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: result beat with nothing pending: %p", $realtime, got);
				return 1'b0;
			end
			want = pending_q.pop_front();
			checked++;
			if (want.fault)
				faults_seen++;
			bad = (got.tenths !== want.tenths) || (got.whole !== want.whole)
				|| (got.pa !== want.pa) || (got.hpa !== want.hpa)
				|| (got.fault !== want.fault);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%t: mismatch tenths %0d/%0d whole %0d/%0d pa %0d/%0d",
						" hpa %0d/%0d fault %0b/%0b (exp/act)"},
						$realtime, want.tenths, got.tenths, want.whole, got.whole,
						want.pa, got.pa, want.hpa, got.hpa, want.fault, got.fault);
			end
			return !bad;
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               raw_valid;
	logic               raw_stall;
	logic        [15:0] raw_temperature;
	logic        [18:0] raw_pressure;
	logic               res_valid;
	logic               res_stall;
	logic signed [15:0] temp_tenths;
	logic signed [12:0] temp_whole;
	logic        [17:0] pressure_pa;
	logic        [11:0] pressure_hpa;
	logic               divide_fault;
	logic               cfg_valid;
	logic               cfg_ready;
	logic        [2:0]  cfg_index;
	logic        [47:0] cfg_data;

	reading_scoreboard readings;
	int raw_pct;       // chance in 100 that the sender idles a cycle
	int res_pct;       // chance in 100 that the receiver stalls a cycle
	int raw_sent;
	int quiet_cycles;
	bit hung;

	baro_sensor_compensation_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.raw_valid      (raw_valid),
		.raw_stall      (raw_stall),
		.raw_temperature(raw_temperature),
		.raw_pressure   (raw_pressure),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.temp_tenths    (temp_tenths),
		.temp_whole     (temp_whole),
		.pressure_pa    (pressure_pa),
		.pressure_hpa   (pressure_hpa),
		.divide_fault   (divide_fault),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Receiver: pick the stall for the next edge on the falling edge.
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < res_pct);
	end

	// Check every result beat at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			void'(readings.check_result({temp_tenths, temp_whole, pressure_pa,
				pressure_hpa, divide_fault}));
	end

	// Watchdog: count edges where no channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (raw_valid && !raw_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT && !hung) begin
			hung = 1'b1;
			$display("timeout: no beat accepted for %0d cycles", HANG_LIMIT);
			$display("baro_sensor_compensation_core_tb failed");
			$finish;
		end
	end

	// Idle mix follows progress: receiver-heavy idling, then sender-heavy, then none.
	function void update_idling();
		if (raw_sent < 430) begin
			raw_pct = 35;
			res_pct = 60;
		end else if (raw_sent < 860) begin
			raw_pct = 60;
			res_pct = 35;
		end else begin
			raw_pct = 0;
			res_pct = 0;
		end
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [47:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		readings.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Send one raw beat, idling at random first; valid stays up until accepted.
	task automatic send_raw(logic [15:0] ut, logic [18:0] up);
		update_idling();
		@(negedge clk);
		while ($urandom_range(99) < raw_pct) begin
			raw_valid = 1'b0;
			raw_temperature = 16'($urandom);
			raw_pressure = 19'($urandom);
			@(negedge clk);
		end
		raw_valid = 1'b1;
		raw_temperature = ut;
		raw_pressure = up;
		@(posedge clk);
		while (raw_stall)
			@(posedge clk);
		readings.note_raw(ut, up);
		raw_sent++;
	endtask

	// Drop valid and hold until every pending result is back, plus pipeline slack.
	task automatic drain();
		@(negedge clk);
		raw_valid = 1'b0;
		while (readings.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick16(cal_kind_t kind, logic [15:0] nominal);
		case (kind)
			CAL_DATASHEET:      return nominal;
			CAL_ZERO:           return 16'h0000;
			CAL_ONES:           return 16'hFFFF;
			CAL_EXTREME:        return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
			CAL_NEAR_DATASHEET: return nominal + 16'($signed(10'($urandom)));
			default:            return 16'($urandom);
		endcase
	endfunction

	// Load a full calibration set; nominal values are the datasheet example.
	task automatic load_cal(cal_kind_t kind, logic [1:0] oss);
		write_reg(CFG_COEF_SIGNED_A, {pick16(kind, 16'd408), pick16(kind, -16'sd72),
			pick16(kind, -16'sd14383)});
		write_reg(CFG_COEF_UNSIGNED_A, {pick16(kind, 16'd32741), pick16(kind, 16'd32757),
			pick16(kind, 16'd23153)});
		write_reg(CFG_COEF_B_PAIR, {16'($urandom), pick16(kind, 16'd6190),
			pick16(kind, 16'd4)});
		write_reg(CFG_COEF_M_PAIR, {16'($urandom), pick16(kind, -16'sd8711),
			pick16(kind, 16'd2868)});
		write_reg(CFG_OVERSAMPLING, {46'($urandom), oss});
	endtask

	task automatic random_raw(cal_kind_t kind);
		logic [15:0] ut;
		logic [18:0] up;
		ut = 16'($urandom);
		up = 19'($urandom);
		// Realistic readings for plausible calibrations, extremes now and then.
		if ((kind == CAL_DATASHEET || kind == CAL_NEAR_DATASHEET) && $urandom_range(3) != 0) begin
			ut = 16'($urandom_range(35000, 18000));
			up = 19'($urandom_range(45000, 15000) << readings.oss);
		end
		case ($urandom_range(15))
			0: ut = 16'hFFFF;
			1: ut = 16'h0000;
			2: up = 19'h7FFFF;
			3: up = 19'h00000;
			default: ;
		endcase
		send_raw(ut, up);
	endtask

	initial begin
		readings = new();
		readings.reset_regs();
		arst_n = 1'b0;
		raw_valid = 1'b0;
		raw_temperature = '0;
		raw_pressure = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_COEF_SIGNED_A;
		cfg_data = '0;
		raw_pct = 35;
		res_pct = 60;
		raw_sent = 0;
		quiet_cycles = 0;
		hung = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset calibration is all zero: every reading is a temperature divide fault.
		send_raw(16'd27898, 19'd23843);
		drain();

		// Datasheet example and field extremes.
		load_cal(CAL_DATASHEET, 2'd0);
		send_raw(16'd27898, 19'd23843);
		send_raw(16'h0000, 19'h00000);
		send_raw(16'hFFFF, 19'h7FFFF);
		send_raw(16'h0000, 19'h7FFFF);
		send_raw(16'hFFFF, 19'h00000);
		send_raw(16'd27898, 19'd95372);
		drain();

		// Out-of-range index must leave the calibration alone.
		write_reg(CFG_UNUSED_IDX, 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_OVERSAMPLING, 48'd3);
		send_raw(16'd27898, 19'd190744);
		send_raw(16'd30000, 19'h7FFFF);
		drain();

		// Temperature divisor cancels exactly: x1 = 1 against md = -1.
		write_reg(CFG_COEF_UNSIGNED_A, {16'd32741, 16'd32768, 16'd23153});
		write_reg(CFG_COEF_M_PAIR, {16'd0, -16'sd8711, -16'sd1});
		send_raw(16'd23154, 19'd23843);
		send_raw(16'd23155, 19'd23843);
		drain();

		// Pressure divisor of zero: ac4 cleared.
		write_reg(CFG_COEF_UNSIGNED_A, {16'd0, 16'd32757, 16'd23153});
		write_reg(CFG_COEF_M_PAIR, {16'd0, -16'sd8711, 16'd2868});
		send_raw(16'd27898, 19'd23843);
		drain();

		// Saturation corners: all-ones and most-negative/most-positive coefficients.
		load_cal(CAL_ONES, 2'd2);
		send_raw(16'h0000, 19'h00000);
		send_raw(16'hFFFF, 19'h7FFFF);
		drain();
		load_cal(CAL_EXTREME, 2'd3);
		send_raw(16'h0000, 19'h7FFFF);
		send_raw(16'hFFFF, 19'h00000);
		send_raw(16'h8000, 19'h40000);
		drain();

		// Random phases, each under a fresh calibration and oversampling setting.
		for (int ph = 0; ph < 12; ph++) begin
			cal_kind_t kind;
			case (ph % 6)
				0: kind = CAL_DATASHEET;
				1: kind = CAL_RANDOM;
				2: kind = CAL_NEAR_DATASHEET;
				3: kind = CAL_EXTREME;
				4: kind = CAL_NEAR_DATASHEET;
				default: kind = (ph == 5) ? CAL_ZERO : CAL_RANDOM;
			endcase
			load_cal(kind, 2'(ph));
			for (int n = 0; n < 106; n++) begin
				random_raw(kind);
				// Hold off once mid-phase until the pipeline is empty.
				if (ph == 4 && n == 50) begin
					@(negedge clk);
					raw_valid = 1'b0;
					while (readings.pending_q.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		$display("covered %0d raw beats, %0d results checked (%0d divide faults),",
			raw_sent, readings.checked, readings.faults_seen);
		$display("across %0d calibration phases and all four oversampling settings; %0d mismatches",
			19, readings.mismatches);
		if (readings.mismatches == 0 && readings.pending_q.size() == 0)
			$display("baro_sensor_compensation_core_tb passed");
		else
			$display("baro_sensor_compensation_core_tb failed");
		$finish;
	end

endmodule
